// File: rtl/cnmf_pkg.sv
// Shared types, constants and helpers of the cross neighbor max filter.
package cnmf_pkg;

    localparam int PIX_W = 32;
    localparam int POS_W = 10;
    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 8;
    localparam int OUT_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 8'd1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic [CFG_W-1:0] ROWS_RESET = 11'd4;
    localparam logic [CFG_W-1:0] COLS_RESET = 11'd5;

    localparam int NUM_SLOTS = 3;
    localparam int SLOT_W = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic signed [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
        logic             lr_ok;
        pix_t             lr_max;
        logic             ud_ok;
        pix_t             ud_max;
    } cnmf_entry_t;

    function automatic slot_t slot_inc(slot_t s);
        slot_t r;
        r = (s == slot_t'(NUM_SLOTS - 1)) ? slot_t'(0) : s + slot_t'(1);
        return r;
    endfunction

    function automatic slot_t slot_dec(slot_t s);
        slot_t r;
        r = (s == slot_t'(0)) ? slot_t'(NUM_SLOTS - 1) : s - slot_t'(1);
        return r;
    endfunction

endpackage

// File: rtl/cnmf_line_bank.sv
// One row slot of the line store: one write port and two registered read ports.
module cnmf_line_bank import cnmf_pkg::*; #(
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr0,
    input  logic [ADDR_W-1:0] rd_addr1,
    output logic [PIX_W-1:0]  rd_data0,
    output logic [PIX_W-1:0]  rd_data1
);

    logic [PIX_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
    end

endmodule

// File: rtl/cnmf_front.sv
// Front part: configuration, raster counters, line store reads and pairwise maxima.
module cnmf_front import cnmf_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_kind,
    input  logic [PIX_W-1:0]     in_pixel,
    input  logic [QCNT_W-1:0]    q_count,
    output logic                 push,
    output cnmf_entry_t          push_entry
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [RW-1:0] ROW_MAX_IDX = RW'(MAX_ROWS - 1);
    localparam logic [CW-1:0] COL_MAX_IDX = CW'(MAX_COLS - 1);

    logic [CFG_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic [CFG_W-1:0] cols_cfg_reg, cols_cfg_next;
    logic [RW-1:0]    in_row_reg, in_row_next;
    logic [CW-1:0]    in_col_reg, in_col_next;
    slot_t            in_slot_reg, in_slot_next;
    logic [RW-1:0]    res_row_reg, res_row_next;
    logic [CW-1:0]    res_col_reg, res_col_next;
    slot_t            res_slot_reg, res_slot_next;
    logic             done_reg, done_next;

    logic             s2_valid_reg;
    logic [POS_W-1:0] s2_row_reg;
    logic [POS_W-1:0] s2_col_reg;
    logic             s2_last_reg;
    logic             s2_hl_reg;
    logic             s2_hr_reg;
    logic             s2_hu_reg;
    logic             s2_hd_reg;
    slot_t            s2_slot_reg;
    slot_t            s2_up_reg;
    pix_t             s2_down_reg;

    logic [RW-1:0]    last_row;
    logic [CW-1:0]    last_col;
    logic             accept;
    logic             pix_take;
    logic             emit;
    logic             res_last;
    logic [QCNT_W-1:0] level;
    logic [PIX_W-1:0] rd0 [0:NUM_SLOTS-1];
    logic [PIX_W-1:0] rd1 [0:NUM_SLOTS-1];
    pix_t             left_v, right_v, up_v;

    always_comb
    begin
        if (rows_cfg_reg == '0)
            last_row = '0;
        else if (int'(rows_cfg_reg) > MAX_ROWS)
            last_row = ROW_MAX_IDX;
        else
            last_row = RW'(rows_cfg_reg - CFG_W'(1));
        if (cols_cfg_reg == '0)
            last_col = '0;
        else if (int'(cols_cfg_reg) > MAX_COLS)
            last_col = COL_MAX_IDX;
        else
            last_col = CW'(cols_cfg_reg - CFG_W'(1));
    end

    // Room is reserved for the beat already in the read stage.
    assign level    = q_count + QCNT_W'(s2_valid_reg);
    assign in_ready = (level < QCNT_W'(QUEUE_DEPTH));
    assign accept   = in_valid && in_ready;
    assign pix_take = accept && (in_kind == KIND_PIXEL) && !done_reg;
    assign emit     = accept && ((in_kind == KIND_DRAIN) ? done_reg
                                                         : (!done_reg && in_row_reg != '0));
    assign res_last = (res_row_reg == last_row) && (res_col_reg == last_col);

    always_comb
    begin
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        res_row_next  = res_row_reg;
        res_col_next  = res_col_reg;
        res_slot_next = res_slot_reg;
        done_next     = done_reg;
        if (cfg_valid)
        begin
            if (cfg_index == REG_FRAME_ROWS || cfg_index == REG_FRAME_COLS)
            begin
                if (cfg_index == REG_FRAME_ROWS)
                    rows_cfg_next = cfg_data;
                else
                    cols_cfg_next = cfg_data;
                in_row_next   = '0;
                in_col_next   = '0;
                in_slot_next  = '0;
                res_row_next  = '0;
                res_col_next  = '0;
                res_slot_next = '0;
                done_next     = 1'b0;
            end
        end
        else
        begin
            if (pix_take)
            begin
                if (in_row_reg == last_row && in_col_reg == last_col)
                begin
                    done_next = 1'b1;
                end
                else if (in_col_reg == last_col)
                begin
                    in_col_next  = '0;
                    in_row_next  = in_row_reg + RW'(1);
                    in_slot_next = slot_inc(in_slot_reg);
                end
                else
                begin
                    in_col_next = in_col_reg + CW'(1);
                end
            end
            if (emit)
            begin
                if (res_last)
                begin
                    in_row_next   = '0;
                    in_col_next   = '0;
                    in_slot_next  = '0;
                    res_row_next  = '0;
                    res_col_next  = '0;
                    res_slot_next = '0;
                    done_next     = 1'b0;
                end
                else if (res_col_reg == last_col)
                begin
                    res_col_next  = '0;
                    res_row_next  = res_row_reg + RW'(1);
                    res_slot_next = slot_inc(res_slot_reg);
                end
                else
                begin
                    res_col_next = res_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= ROWS_RESET;
            cols_cfg_reg <= COLS_RESET;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            res_row_reg  <= '0;
            res_col_reg  <= '0;
            res_slot_reg <= '0;
            done_reg     <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            res_row_reg  <= res_row_next;
            res_col_reg  <= res_col_next;
            res_slot_reg <= res_slot_next;
            done_reg     <= done_next;
            s2_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s2_row_reg  <= POS_W'(res_row_reg);
            s2_col_reg  <= POS_W'(res_col_reg);
            s2_last_reg <= res_last;
            s2_hl_reg   <= (res_col_reg != '0);
            s2_hr_reg   <= (res_col_reg != last_col);
            s2_hu_reg   <= (res_row_reg != '0);
            s2_hd_reg   <= (in_kind == KIND_PIXEL);
            s2_slot_reg <= res_slot_reg;
            s2_up_reg   <= slot_dec(res_slot_reg);
            s2_down_reg <= in_pixel;
        end
    end

    // The result row sits in its own slot; the row above in the slot before it.
    for (genvar b = 0; b < NUM_SLOTS; b++)
    begin : g_bank
        cnmf_line_bank #(
            .ADDR_W(CW)
        ) u_bank (
            .clk      (clk),
            .wr_en    (pix_take && (in_slot_reg == slot_t'(b))),
            .wr_addr  (in_col_reg),
            .wr_data  (in_pixel),
            .rd_en    (emit),
            .rd_addr0 ((res_slot_reg == slot_t'(b)) ? res_col_reg - CW'(1) : res_col_reg),
            .rd_addr1 (res_col_reg + CW'(1)),
            .rd_data0 (rd0[b]),
            .rd_data1 (rd1[b])
        );
    end

    always_comb
    begin
        left_v  = rd0[s2_slot_reg];
        right_v = rd1[s2_slot_reg];
        up_v    = rd0[s2_up_reg];

        push_entry.row   = s2_row_reg;
        push_entry.col   = s2_col_reg;
        push_entry.last  = s2_last_reg;
        push_entry.lr_ok = s2_hl_reg || s2_hr_reg;
        if (s2_hl_reg && s2_hr_reg)
            push_entry.lr_max = (left_v > right_v) ? left_v : right_v;
        else if (s2_hl_reg)
            push_entry.lr_max = left_v;
        else
            push_entry.lr_max = right_v;
        push_entry.ud_ok = s2_hu_reg || s2_hd_reg;
        if (s2_hu_reg && s2_hd_reg)
            push_entry.ud_max = (up_v > s2_down_reg) ? up_v : s2_down_reg;
        else if (s2_hu_reg)
            push_entry.ud_max = up_v;
        else
            push_entry.ud_max = s2_down_reg;
    end

    assign push = s2_valid_reg;

endmodule

// File: rtl/cnmf_queue.sv
// Short queue of partial results between the front and back parts.
module cnmf_queue import cnmf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cnmf_entry_t       push_entry,
    input  logic              pop,
    output cnmf_entry_t       head,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    cnmf_entry_t       mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

// File: rtl/cnmf_back.sv
// Back part: final maximum and the output register of the result stream.
module cnmf_back import cnmf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  cnmf_entry_t      q_head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [POS_W-1:0] out_row,
    output logic [POS_W-1:0] out_col,
    output logic [PIX_W-1:0] out_max,
    output logic             out_last
);

    logic             out_valid_reg;
    logic [POS_W-1:0] out_row_reg;
    logic [POS_W-1:0] out_col_reg;
    pix_t             out_max_reg, out_max_next;
    logic             out_last_reg;

    assign pop = !q_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (q_head.lr_ok && q_head.ud_ok)
            out_max_next = (q_head.lr_max > q_head.ud_max) ? q_head.lr_max : q_head.ud_max;
        else if (q_head.lr_ok)
            out_max_next = q_head.lr_max;
        else if (q_head.ud_ok)
            out_max_next = q_head.ud_max;
        else
            out_max_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_row_reg  <= q_head.row;
            out_col_reg  <= q_head.col;
            out_max_reg  <= out_max_next;
            out_last_reg <= q_head.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_max   = out_max_reg;
    assign out_last  = out_last_reg;

endmodule

// File: rtl/cross_neighbor_max_filter.sv
// Top level of the cross neighbor max filter with stream and configuration ports.
// The filter takes one beat per clock while s_tready is high, pixels in raster
// order or drain beats, and gives for each position the maximum of its in-frame
// up, down, left and right neighbors (0 for a 1x1 frame). A result leaves when the
// pixel below it arrives; the final row is pushed out by drain beats, one result
// each, and m_tlast marks the last position. The sustained rate is one beat per
// clock while the output is not stalled, set by the three line store banks, which
// take one write and two reads each cycle. A result passes from the line store
// read registers and the read stage registers into the queue, and from the queue
// into the output register. A stalled output fills the four-entry queue and then
// holds s_tready low until the queue drains. The line store is not cleared after
// reset; no clearing pass is needed. Register writes restart the frame; the user
// ensures they are made only while the filter is idle; the filter has no such check.
module cross_neighbor_max_filter import cnmf_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // pixel_value
    input  logic [0:0]            s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_row, out_col, neighbor_max, zero fill
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cnmf_entry_t       push_entry;
    cnmf_entry_t       q_head;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic [PIX_W-1:0]  out_max;

    assign cfg_ready = 1'b1;

    cnmf_front #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser[0]),
        .in_pixel   (s_tdata),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry)
    );

    cnmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .empty      (q_empty),
        .count      (q_count)
    );

    cnmf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_max   (out_max),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(OUT_DATA_W - 2 * POS_W - PIX_W){1'b0}}, out_max, out_col, out_row};

endmodule

// File: rtl/cnmf_checker.sv
// Port-level checker of the result stream hold and order, bound to the top level.
module cnmf_checker import cnmf_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    logic             beat;
    logic [POS_W-1:0] cur_row;
    logic [POS_W-1:0] cur_col;
    logic             seen_reg;
    logic [POS_W-1:0] prev_row_reg;
    logic [POS_W-1:0] prev_col_reg;
    logic             prev_last_reg;

    assign beat    = m_tvalid && m_tready;
    assign cur_row = m_tdata[POS_W-1:0];
    assign cur_col = m_tdata[2*POS_W-1:POS_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_row_reg  <= '0;
            prev_col_reg  <= '0;
            prev_last_reg <= 1'b0;
        end
        else if (beat)
        begin
            seen_reg      <= 1'b1;
            prev_row_reg  <= cur_row;
            prev_col_reg  <= cur_col;
            prev_last_reg <= m_tlast;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        beat && seen_reg && cur_col != '0 |->
            prev_row_reg == cur_row && prev_col_reg == cur_col - POS_W'(1))
        else $error("result column out of order");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        beat && seen_reg && cur_col == '0 && cur_row != '0 |->
            prev_row_reg == cur_row - POS_W'(1) && !prev_last_reg)
        else $error("result row out of order");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        beat && seen_reg && prev_last_reg |-> cur_row == '0 && cur_col == '0)
        else $error("frame does not restart at the first position");

endmodule

bind cross_neighbor_max_filter cnmf_checker u_checker (.*);
